// ===== rtl/jet_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Julia escape-time block.
// Used by jet_mul and julia_escape_time_top; depends on nothing else.

package jet_pkg;

    // Field and datapath widths.
    localparam int unsigned IN_W      = 32;
    localparam int unsigned Z_W       = 40;
    localparam int unsigned HALF_W    = Z_W / 2;
    localparam int unsigned PROD_W    = 2 * Z_W;
    localparam int unsigned WIDE_W    = PROD_W + 1;
    localparam int unsigned LIMIT_W   = 12;
    localparam int unsigned R2_W      = 36;
    localparam int unsigned CFG_W     = 36;
    localparam int unsigned CFG_IDX_W = 2;

    // Default fraction bits and register reset values.
    localparam int unsigned       FRAC_BITS_DEF = 28;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 12'd100;
    localparam logic [R2_W-1:0]    R2_RESET     = 36'h0_4000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT = 2'd0,
        CFG_CRE   = 2'd1,
        CFG_CIM   = 2'd2,
        CFG_R2    = 2'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_XY,
        ST_DIFF,
        ST_NEW,
        ST_SUM,
        ST_CMP,
        ST_DONE
    } t_state;

    // Request to the shared multiplier.
    typedef struct packed {
        logic                   start;
        logic signed [Z_W-1:0]  a;
        logic signed [Z_W-1:0]  b;
    } t_mul_req;

    // Response from the shared multiplier.
    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } t_mul_rsp;

endpackage

// ===== rtl/julia_escape_time_top.sv =====
`timescale 1ns / 1ps
// Top level of the Julia escape-time block: sequencer, iteration datapath,
// configuration registers and output register. Depends on jet_pkg and jet_mul.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one starting point per beat.
//   Output channel (o_out_valid / i_out_stall) returns one result beat per point:
//   escape index, escaped flag and the final z in signed Q12.F.
//   The configuration port writes one register per cycle with i_cfg_we high;
//   write it only while no point is in flight.
//
// Timing:
//   Every product goes through one shared 20x20 multiplier.
//   With the limit at zero no iteration runs and the sequencer goes straight
//   from idle to done, so the start point comes back as the final z.
//   One point is worked on at a time; o_in_stall stays high until the result
//   sits in the output register.
//
// Reset and stall:
//   Synchronous active-low reset clears the sequencer and output valid and
//   restores the register defaults (limit 100, c = 0, bailout 4.0).
//   While the receiver stalls, the result beat holds; a finished point waits
//   in the sequencer until the output register frees up.

module julia_escape_time_top
    import jet_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [IN_W-1:0]    i_start_real,
    input  logic signed [IN_W-1:0]    i_start_imag,
    // Output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [LIMIT_W-1:0]        o_escape_index,
    output logic                      o_escaped,
    output logic signed [Z_W-1:0]     o_final_real,
    output logic signed [Z_W-1:0]     o_final_imag,
    // Configuration port
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    // Saturation bounds of z, widened to the intermediate width.
    localparam logic signed [WIDE_W-1:0] SAT_HI =
        {{(WIDE_W-Z_W+1){1'b0}}, {(Z_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_LO =
        {{(WIDE_W-Z_W+1){1'b1}}, {(Z_W-1){1'b0}}};

    // Configuration registers.
    logic [LIMIT_W-1:0]       r_limit;
    logic signed [IN_W-1:0]   r_cre;
    logic signed [IN_W-1:0]   r_cim;
    logic [R2_W-1:0]          r_r2;

    // Sequencer.
    t_state r_state;
    t_state n_state;
    logic   r_enter;

    // Iteration datapath.
    logic signed [Z_W-1:0]    r_x;
    logic signed [Z_W-1:0]    r_y;
    logic signed [PROD_W-1:0] r_xx;
    logic signed [PROD_W-1:0] r_yy;
    logic signed [PROD_W-1:0] r_xy;
    logic signed [WIDE_W-1:0] r_re_w;
    logic signed [WIDE_W-1:0] r_im_w;
    logic [PROD_W-1:0]        r_mag;
    logic [LIMIT_W-1:0]       r_k;
    logic                     r_fresh;
    logic [LIMIT_W-1:0]       r_idx;
    logic                     r_esc;

    // Output register.
    logic                     r_out_valid;
    logic [LIMIT_W-1:0]       r_o_idx;
    logic                     r_o_esc;
    logic signed [Z_W-1:0]    r_o_re;
    logic signed [Z_W-1:0]    r_o_im;

    // Combinational helpers.
    t_mul_req                 mul_req;
    t_mul_rsp                 mul_rsp;
    logic                     in_accept;
    logic                     load_out;
    logic                     escape_hit;
    logic                     last_iter;
    logic [PROD_W-1:0]        bound;
    logic signed [WIDE_W-1:0] re_sum;
    logic signed [WIDE_W-1:0] im_sum;
    logic signed [Z_W-1:0]    re_sat;
    logic signed [Z_W-1:0]    im_sat;

    jet_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_cre   <= '0;
            r_cim   <= '0;
            r_r2    <= R2_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_CRE:   r_cre   <= $signed(i_cfg_data[IN_W-1:0]);
                CFG_CIM:   r_cim   <= $signed(i_cfg_data[IN_W-1:0]);
                CFG_R2:    r_r2    <= i_cfg_data[R2_W-1:0];
                default:   ;
            endcase
        end
    end

    // Handshake terms and the escape test.
    assign in_accept  = i_in_valid && !o_in_stall;
    assign bound      = PROD_W'(r_r2) << FRAC_BITS;
    assign escape_hit = r_mag > bound;
    assign last_iter  = ({1'b0, r_k} + 1'b1) == {1'b0, r_limit};

    // New z: shift, add c, clamp to the 40-bit range.
    always_comb begin
        re_sum = (r_re_w >>> FRAC_BITS) + WIDE_W'(r_cre);
        im_sum = (r_im_w >>> FRAC_BITS) + WIDE_W'(r_cim);
        if (re_sum > SAT_HI) begin
            re_sat = SAT_HI[Z_W-1:0];
        end else if (re_sum < SAT_LO) begin
            re_sat = SAT_LO[Z_W-1:0];
        end else begin
            re_sat = re_sum[Z_W-1:0];
        end
        if (im_sum > SAT_HI) begin
            im_sat = SAT_HI[Z_W-1:0];
        end else if (im_sum < SAT_LO) begin
            im_sat = SAT_LO[Z_W-1:0];
        end else begin
            im_sat = im_sum[Z_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (r_limit == '0) ? ST_DONE : ST_SQX;
                end
            end
            ST_SQX: begin
                if (mul_rsp.done) begin
                    n_state = ST_SQY;
                end
            end
            ST_SQY: begin
                if (mul_rsp.done) begin
                    n_state = r_fresh ? ST_XY : ST_SUM;
                end
            end
            ST_XY: begin
                if (mul_rsp.done) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: n_state = ST_NEW;
            ST_NEW:  n_state = ST_SQX;
            ST_SUM:  n_state = ST_CMP;
            ST_CMP: begin
                n_state = (escape_hit || last_iter) ? ST_DONE : ST_XY;
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier requests, input stall, output load.
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = r_x;
        mul_req.b     = r_x;
        unique case (r_state)
            ST_SQX: begin
                mul_req.start = r_enter;
            end
            ST_SQY: begin
                mul_req.start = r_enter;
                mul_req.a     = r_y;
                mul_req.b     = r_y;
            end
            ST_XY: begin
                mul_req.start = r_enter;
                mul_req.b     = r_y;
            end
            default: ;
        endcase
        o_in_stall = (r_state != ST_IDLE);
        load_out   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    // State register and the first-cycle marker that launches a product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_enter <= 1'b0;
        end else begin
            r_state <= n_state;
            r_enter <= (n_state != r_state);
        end
    end

    // Iteration datapath, stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_x     <= Z_W'(i_start_real);
                    r_y     <= Z_W'(i_start_imag);
                    r_k     <= '0;
                    r_fresh <= 1'b1;
                    r_idx   <= '0;
                    r_esc   <= 1'b0;
                end
            end
            ST_SQX: begin
                if (mul_rsp.done) begin
                    r_xx <= mul_rsp.prod;
                end
            end
            ST_SQY: begin
                if (mul_rsp.done) begin
                    r_yy <= mul_rsp.prod;
                end
            end
            ST_XY: begin
                if (mul_rsp.done) begin
                    r_xy    <= mul_rsp.prod;
                    r_fresh <= 1'b0;
                end
            end
            ST_DIFF: begin
                r_re_w <= WIDE_W'(r_xx - r_yy);
                r_im_w <= WIDE_W'(r_xy) <<< 1;
            end
            ST_NEW: begin
                r_x <= re_sat;
                r_y <= im_sat;
            end
            ST_SUM: begin
                r_mag <= $unsigned(r_xx) + $unsigned(r_yy);
            end
            ST_CMP: begin
                if (escape_hit) begin
                    r_idx <= r_k;
                    r_esc <= 1'b1;
                end else if (!last_iter) begin
                    r_k <= r_k + 1'b1;
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // Output register: holds the beat while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_idx <= r_idx;
            r_o_esc <= r_esc;
            r_o_re  <= r_x;
            r_o_im  <= r_y;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_escape_index = r_o_idx;
    assign o_escaped      = r_o_esc;
    assign o_final_real   = r_o_re;
    assign o_final_imag   = r_o_im;

    // A product completes only while the sequencer waits on the multiplier.
    a_mul_done_in_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == ST_SQX || r_state == ST_SQY || r_state == ST_XY))
        else $error("multiplier finished outside a multiply state");

    // An accepted point always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != ST_IDLE))
        else $error("accepted point did not start work");

    // Loading a result always presents a beat on the next cycle.
    a_load_shows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_out_valid)
        else $error("loaded result not shown on the output");

endmodule

// ===== rtl/jet_mul.sv =====
`timescale 1ns / 1ps
// Shared signed 40x40 multiplier built from one 20x20 unsigned multiplier.
// Depends on jet_pkg for widths and the request/response structs.

module jet_mul
    import jet_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic              r_busy;
    logic [2:0]        r_step;
    logic              r_done;
    logic [Z_W-1:0]    r_mag_a;
    logic [Z_W-1:0]    r_mag_b;
    logic              r_neg;
    logic [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] r_prod;

    logic [HALF_W-1:0]   a_half;
    logic [HALF_W-1:0]   b_half;
    logic [2*HALF_W-1:0] pp;
    logic [PROD_W-1:0]   pp_sh;
    logic [Z_W-1:0]      mag_a;
    logic [Z_W-1:0]      mag_b;

    // Magnitudes of the operands; the most negative value still fits unsigned.
    assign mag_a = i_req.a[Z_W-1] ? (~i_req.a + 1'b1) : i_req.a;
    assign mag_b = i_req.b[Z_W-1] ? (~i_req.b + 1'b1) : i_req.b;

    // One partial product per step: step bit 1 picks the half of a, bit 0 of b.
    always_comb begin
        a_half = r_step[1] ? r_mag_a[Z_W-1:HALF_W] : r_mag_a[HALF_W-1:0];
        b_half = r_step[0] ? r_mag_b[Z_W-1:HALF_W] : r_mag_b[HALF_W-1:0];
        pp     = a_half * b_half;
        case ({r_step[1], r_step[0]})
            2'b00:   pp_sh = {{(2*HALF_W){1'b0}}, pp};
            2'b11:   pp_sh = {pp, {(2*HALF_W){1'b0}}};
            default: pp_sh = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
        endcase
    end

    // Control: four accumulate steps, then one step to apply the sign.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    // Datapath: operand capture, accumulation and sign correction.
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_mag_a <= mag_a;
            r_mag_b <= mag_b;
            r_neg   <= i_req.a[Z_W-1] ^ i_req.b[Z_W-1];
            r_acc   <= '0;
        end else if (r_busy) begin
            if (r_step == LAST_STEP) begin
                r_prod <= r_neg ? $signed(~r_acc + 1'b1) : $signed(r_acc);
            end else begin
                r_acc <= r_acc + pp_sh;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;

endmodule

// ===== sim/julia_escape_time_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for julia_escape_time_top: directed and random points
// under several register settings and idling patterns. Depends on jet_pkg.

module julia_escape_time_top_test;
    import jet_pkg::*;

    localparam int unsigned FRAC        = FRAC_BITS_DEF;
    localparam int unsigned N_PHASES    = 16;
    localparam int unsigned PER_PHASE   = 105;
    localparam int unsigned PRESS_PHASE = 6;
    localparam int unsigned HOLD_CYCLES = 3000;

    localparam logic signed [IN_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [IN_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [IN_W-1:0] ONE   = 32'sh1000_0000;

    // One result beat as the block reports it.
    typedef struct packed {
        logic [LIMIT_W-1:0]    index;
        logic                  escaped;
        logic signed [Z_W-1:0] re;
        logic signed [Z_W-1:0] im;
    } t_escape_res;

    // Predicts the escape result of each accepted point and checks result beats in order.
    class escape_scoreboard;
        logic [LIMIT_W-1:0]     limit;
        logic signed [IN_W-1:0] c_re;
        logic signed [IN_W-1:0] c_im;
        logic [R2_W-1:0]        radius_sq;
        t_escape_res            expected_results[$];
        int unsigned            errors;

        function void restore_defaults();
            limit     = LIMIT_RESET;
            c_re      = '0;
            c_im      = '0;
            radius_sq = R2_RESET;
            errors    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_LIMIT: limit     = data[LIMIT_W-1:0];
                CFG_CRE:   c_re      = data[IN_W-1:0];
                CFG_CIM:   c_im      = data[IN_W-1:0];
                CFG_R2:    radius_sq = data[R2_W-1:0];
                default: ;
            endcase
        endfunction

        // Clamp a wide value to the signed Q12.F range of z.
        function logic signed [127:0] clamp_z(logic signed [127:0] v);
            logic signed [127:0] zmax;
            logic signed [127:0] zmin;
            zmax = (128'sd1 <<< (Z_W - 1)) - 128'sd1;
            zmin = -(128'sd1 <<< (Z_W - 1));
            if (v > zmax)
                return zmax;
            if (v < zmin)
                return zmin;
            return v;
        endfunction

        // Run z = z*z + c exactly in wide integers until escape or the limit.
        function t_escape_res iterate_point(logic signed [IN_W-1:0] sr,
                                            logic signed [IN_W-1:0] si);
            logic signed [127:0] x;
            logic signed [127:0] y;
            logic signed [127:0] re;
            logic signed [127:0] im;
            logic signed [127:0] mag2;
            logic signed [127:0] bound;
            t_escape_res         res;
            int                  k;
            x     = sr;
            y     = si;
            bound = {92'd0, radius_sq} << FRAC;
            res   = '0;
            for (k = 0; k < int'(limit); k++) begin
                re   = ((x * x - y * y) >>> FRAC) + c_re;
                im   = ((x * y + x * y) >>> FRAC) + c_im;
                x    = clamp_z(re);
                y    = clamp_z(im);
                mag2 = x * x + y * y;
                if (mag2 > bound) begin
                    res.index   = k[LIMIT_W-1:0];
                    res.escaped = 1'b1;
                    break;
                end
            end
            res.re = x[Z_W-1:0];
            res.im = y[Z_W-1:0];
            return res;
        endfunction

        function void note_point(logic signed [IN_W-1:0] sr, logic signed [IN_W-1:0] si);
            expected_results.push_back(iterate_point(sr, si));
        endfunction

        function void check_result(t_escape_res got);
            t_escape_res exp_res;
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: idx %0d esc %0b re %0d im %0d",
                         $time, got.index, got.escaped, got.re, got.im);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (got.index !== exp_res.index) begin
                $display("%0t: escape_index expected %0d actual %0d",
                         $time, exp_res.index, got.index);
                errors++;
            end
            if (got.escaped !== exp_res.escaped) begin
                $display("%0t: escaped expected %0b actual %0b",
                         $time, exp_res.escaped, got.escaped);
                errors++;
            end
            if (got.re !== exp_res.re) begin
                $display("%0t: final_real expected %0d actual %0d", $time, exp_res.re, got.re);
                errors++;
            end
            if (got.im !== exp_res.im) begin
                $display("%0t: final_imag expected %0d actual %0d", $time, exp_res.im, got.im);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic signed [IN_W-1:0] start_real = '0;
    logic signed [IN_W-1:0] start_imag = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [LIMIT_W-1:0]     escape_index;
    logic                   escaped;
    logic signed [Z_W-1:0]  final_real;
    logic signed [Z_W-1:0]  final_imag;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    escape_scoreboard sb = new();

    julia_escape_time_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_start_real   (start_real),
        .i_start_imag   (start_imag),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_escape_index (escape_index),
        .o_escaped      (escaped),
        .o_final_real   (final_real),
        .o_final_imag   (final_imag),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard limit on the run time.
    initial begin
        #100_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic bit roll(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // Receiver stall: a requested long hold-off first, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= roll(recv_stall_pct);
        end
    end

    // Check every result beat taken at a rising edge.
    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{escape_index, escaped, final_real, final_imag});
    end

    // Offer one point; entered and left at a falling edge with valid still high.
    task automatic send_point(input logic signed [IN_W-1:0] sr,
                              input logic signed [IN_W-1:0] si);
        while (roll(send_idle_pct)) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        start_real <= sr;
        start_imag <= si;
        do
            @(posedge i_clk);
        while (in_stall);
        sb.note_point(sr, si);
        @(negedge i_clk);
    endtask

    // Lower valid and wait until every expected result beat has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly points inside the interesting disc, some full range, some edges.
    function automatic logic signed [IN_W-1:0] pick_coord();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return int'($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
        if (r < 90)
            return $urandom;
        case ($urandom_range(3))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            default: return -32'sd1;
        endcase
    endfunction

    // Constant part: small, full range or zero; upper data bits are don't-care.
    function automatic logic [CFG_W-1:0] pick_const();
        logic [CFG_W-1:0] d;
        d = CFG_W'({$urandom, $urandom});
        case ($urandom_range(3))
            0, 1:    d[IN_W-1:0] = int'($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
            2:       ;
            default: d[IN_W-1:0] = '0;
        endcase
        return d;
    endfunction

    function automatic logic [CFG_W-1:0] pick_radius();
        case ($urandom_range(5))
            0:       return CFG_W'(R2_RESET);
            1:       return CFG_W'($urandom_range(32'hFFFF_FFFF));
            2:       return CFG_W'({$urandom, $urandom});
            3:       return '0;
            4:       return '1;
            default: return CFG_W'($urandom_range(32'h1000_0000, 32'h4_0000));
        endcase
    endfunction

    task automatic configure_phase(input int unsigned ph);
        logic [CFG_W-1:0] lim;
        lim = CFG_W'({$urandom, $urandom});
        if (ph == 0)
            lim[LIMIT_W-1:0] = 12'd1;
        else if (ph == 1)
            lim[LIMIT_W-1:0] = 12'd32;
        else
            lim[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 32));
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_CRE, pick_const());
        write_reg(CFG_CIM, pick_const());
        write_reg(CFG_R2, pick_radius());
    endtask

    initial begin
        int unsigned ph;
        int unsigned n;
        sb.restore_defaults();
        repeat (6) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: points that stay bounded, escape late and escape at once.
        send_point('0, '0);
        send_point(ONE, '0);
        send_point(-ONE, '0);
        send_point('0, ONE);
        send_point(32'sh1199_999A, '0);
        send_point(C_MAX, C_MAX);
        send_point(C_MIN, C_MIN);
        send_point(C_MIN, C_MAX);
        send_point(C_MAX, C_MIN);
        send_point(C_MIN, '0);
        send_point('0, C_MIN);
        drain();

        // Zero limit: the start point comes back sign extended.
        write_reg(CFG_LIMIT, '0);
        send_point(C_MIN, C_MAX);
        send_point(32'sh8765_4321, 32'sh1234_5678);
        send_point(-32'sd1, 32'sd1);
        drain();

        // Largest limit with a zero bailout: one full run and one escape.
        write_reg(CFG_LIMIT, CFG_W'(12'hFFF));
        write_reg(CFG_R2, '0);
        send_point('0, '0);
        send_point(32'sh0000_4000, 32'sh0000_4000);
        drain();

        // One iteration with extreme constants and the largest bailout.
        write_reg(CFG_LIMIT, CFG_W'(12'd1));
        write_reg(CFG_CRE, CFG_W'(C_MAX));
        write_reg(CFG_CIM, {4'hF, C_MIN});
        write_reg(CFG_R2, '1);
        send_point(C_MAX, C_MAX);
        send_point('0, '0);
        send_point(C_MIN, C_MIN);
        drain();

        // A classic connected Julia constant, about -0.8 + 0.156i.
        write_reg(CFG_LIMIT, CFG_W'(12'd64));
        write_reg(CFG_CRE, CFG_W'(-32'sd214748365));
        write_reg(CFG_CIM, CFG_W'(32'sd41875931));
        write_reg(CFG_R2, CFG_W'(R2_RESET));
        send_point(32'sh0400_0000, 32'sh0200_0000);
        send_point(-32'sh0800_0000, 32'sh0100_0000);
        send_point(32'sh0C00_0000, -32'sh0600_0000);
        drain();

        // Random phases, each with its own settings and idling pattern.
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default: begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            configure_phase(ph);
            // Long receiver hold-off so the block backs up into its input.
            if (ph == PRESS_PHASE)
                hold_req++;
            for (n = 0; n < PER_PHASE; n++)
                send_point(pick_coord(), pick_coord());
            drain();
        end

        repeat (50) @(negedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/jet_pkg.sv
rtl/jet_mul.sv
rtl/julia_escape_time_top.sv
sim/julia_escape_time_top_test.sv
